>>> rtl/core/tcpu_pkg.sv
// ----------------------------------------------------------------------------
// tcpu_pkg: shared types and constants of the tiny 8-bit processor step block
// Opcodes, status codes, memory geometry and the request and result words
// that pass between the top level and the execution core.
// ----------------------------------------------------------------------------
package tcpu_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int REG_COUNT = 8;
  localparam int RF_AW     = $clog2(REG_COUNT);

  localparam logic [15:0] CODE_BEGIN_RST = 16'h0000;
  localparam logic [15:0] CODE_END_RST   = 16'h8000;

  localparam logic CFG_CODE_BEGIN = 1'b0;
  localparam logic CFG_CODE_END   = 1'b1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EXEC  = 1'b1;

  localparam logic [RF_AW-1:0] REG_ADDR_HI = RF_AW'(6);
  localparam logic [RF_AW-1:0] REG_ADDR_LO = RF_AW'(7);

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_HALT       = 3'd1;
  localparam logic [2:0] ST_PC_OUT     = 3'd2;
  localparam logic [2:0] ST_STORE_CODE = 3'd3;
  localparam logic [2:0] ST_BAD_OP     = 3'd4;

  localparam logic [7:0] OP_LOADI = 8'd0;
  localparam logic [7:0] OP_LOAD  = 8'd1;
  localparam logic [7:0] OP_STORE = 8'd2;
  localparam logic [7:0] OP_ADD   = 8'd3;
  localparam logic [7:0] OP_SUB   = 8'd4;
  localparam logic [7:0] OP_INC   = 8'd5;
  localparam logic [7:0] OP_DEC   = 8'd6;
  localparam logic [7:0] OP_AND   = 8'd7;
  localparam logic [7:0] OP_OR    = 8'd8;
  localparam logic [7:0] OP_XOR   = 8'd9;
  localparam logic [7:0] OP_JMP   = 8'd10;
  localparam logic [7:0] OP_JZ    = 8'd11;
  localparam logic [7:0] OP_JNZ   = 8'd12;
  localparam logic [7:0] OP_HALT  = 8'd13;

  typedef struct packed {
    logic        req_type;
    logic [15:0] load_address;
    logic [7:0]  load_data;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] program_counter;
    logic        carry_flag;
    logic        zero_flag;
    logic [2:0]  target_register;
    logic [7:0]  target_value;
  } res_t;

endpackage

>>> rtl/core/tcpu_mem.sv
// ----------------------------------------------------------------------------
// tcpu_mem: single-port byte memory
// One access per cycle, either a write or a read; read data is registered
// and holds its value while no read is issued.
// ----------------------------------------------------------------------------
module tcpu_mem
  import tcpu_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [MEM_AW-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/tcpu_regfile.sv
// ----------------------------------------------------------------------------
// tcpu_regfile: eight-entry byte register file
// Two registered read ports and one write port. Per-entry valid bits make
// every entry read as zero until it is first written after reset.
// ----------------------------------------------------------------------------
module tcpu_regfile
  import tcpu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             re0,
  input  logic [RF_AW-1:0] ra0,
  output logic [7:0]       rd0,
  input  logic             re1,
  input  logic [RF_AW-1:0] ra1,
  output logic [7:0]       rd1,
  input  logic             we,
  input  logic [RF_AW-1:0] wa,
  input  logic [7:0]       wd
);

  logic [7:0]           regs [REG_COUNT];
  logic [REG_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      regs[wa] <= wd;
    end
    if (re0) begin
      rd0 <= valid[ra0] ? regs[ra0] : 8'h00;
    end
    if (re1) begin
      rd1 <= valid[ra1] ? regs[ra1] : 8'h00;
    end
  end

endmodule

>>> rtl/core/tcpu_core.sv
// ----------------------------------------------------------------------------
// tcpu_core: instruction sequencer and execution datapath
// Fetches the three instruction bytes from the byte memory, reads operands
// from the register file, executes and writes back, one request at a time.
// ----------------------------------------------------------------------------
module tcpu_core
  import tcpu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] code_begin,
  input  logic [15:0] code_end,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  typedef enum logic [2:0] {S_IDLE, S_F1, S_F2, S_EX, S_WB} state_t;

  state_t      state;
  logic [15:0] pc;
  logic        carry;
  logic        zero;
  logic [7:0]  op;
  logic [7:0]  a1;
  logic [7:0]  a2;
  logic [15:0] daddr;

  logic              mem_en;
  logic              mem_we;
  logic [15:0]       mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_q;
  logic              rf_re0;
  logic              rf_re1;
  logic [RF_AW-1:0]  rf_ra0;
  logic [RF_AW-1:0]  rf_ra1;
  logic [7:0]        rf_rd0;
  logic [7:0]        rf_rd1;
  logic              rf_we;

  logic        pc_out;
  logic        in_code;
  logic        res_free;
  logic        idle_fire;
  logic        wb_fire;
  logic [8:0]  sum;
  logic [7:0]  wval;
  logic        wr_reg;
  logic        do_store;
  logic        set_z;
  logic        carry_next;
  logic        zero_next;
  logic [15:0] pc_next;
  logic [2:0]  st;

  tcpu_mem u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr[MEM_AW-1:0]),
    .wdata (mem_wdata),
    .rdata (mem_q)
  );

  tcpu_regfile u_rf (
    .clk (clk),
    .rst (rst),
    .re0 (rf_re0),
    .ra0 (rf_ra0),
    .rd0 (rf_rd0),
    .re1 (rf_re1),
    .ra1 (rf_ra1),
    .rd1 (rf_rd1),
    .we  (rf_we),
    .wa  (a1[RF_AW-1:0]),
    .wd  (wval)
  );

  assign pc_out  = (pc < code_begin) || (({1'b0, pc} + 17'd2) >= {1'b0, code_end});
  assign in_code = (daddr >= code_begin) && (daddr < code_end);
  assign sum     = {1'b0, rf_rd0} + {1'b0, rf_rd1};

  always_comb begin
    wval     = rf_rd0;
    wr_reg   = 1'b0;
    do_store = 1'b0;
    set_z    = 1'b0;
    carry_next = carry;
    pc_next  = pc + 16'd3;
    st       = ST_OK;
    case (op)
      OP_LOADI: begin
        wval   = a2;
        wr_reg = 1'b1;
      end
      OP_LOAD: begin
        wval   = mem_q;
        wr_reg = 1'b1;
      end
      OP_STORE: begin
        if (in_code) begin
          st = ST_STORE_CODE;
        end else begin
          do_store = 1'b1;
        end
      end
      OP_ADD: begin
        wval       = sum[7:0];
        carry_next = sum[8];
        wr_reg     = 1'b1;
        set_z      = 1'b1;
      end
      OP_SUB: begin
        wval       = rf_rd0 - rf_rd1;
        carry_next = rf_rd0 < rf_rd1;
        wr_reg     = 1'b1;
        set_z      = 1'b1;
      end
      OP_INC: begin
        wval       = rf_rd0 + 8'd1;
        carry_next = 1'b0;
        wr_reg     = 1'b1;
        set_z      = 1'b1;
      end
      OP_DEC: begin
        wval       = rf_rd0 - 8'd1;
        carry_next = 1'b0;
        wr_reg     = 1'b1;
        set_z      = 1'b1;
      end
      OP_AND: begin
        wval       = rf_rd0 & rf_rd1;
        carry_next = 1'b0;
        wr_reg     = 1'b1;
        set_z      = 1'b1;
      end
      OP_OR: begin
        wval       = rf_rd0 | rf_rd1;
        carry_next = 1'b0;
        wr_reg     = 1'b1;
        set_z      = 1'b1;
      end
      OP_XOR: begin
        wval       = rf_rd0 ^ rf_rd1;
        carry_next = 1'b0;
        wr_reg     = 1'b1;
        set_z      = 1'b1;
      end
      OP_JMP: begin
        pc_next = {a1, a2};
      end
      OP_JZ: begin
        if (zero) begin
          pc_next = {a1, a2};
        end
      end
      OP_JNZ: begin
        if (!zero) begin
          pc_next = {a1, a2};
        end
      end
      OP_HALT: begin
        st = ST_HALT;
      end
      default: begin
        st = ST_BAD_OP;
      end
    endcase
    zero_next = set_z ? (wval == 8'h00) : zero;
  end

  assign res_free  = !res_valid || res_ready;
  assign idle_fire = (state == S_IDLE) && req_valid &&
                     ((req.req_type == REQ_WRITE) || pc_out) && res_free;
  assign wb_fire   = (state == S_WB) && res_free;

  always_comb begin
    req_ready = 1'b0;
    if (state == S_IDLE) begin
      if ((req.req_type == REQ_WRITE) || pc_out) begin
        req_ready = res_free;
      end else begin
        req_ready = 1'b1;
      end
    end
  end

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = pc;
    mem_wdata = rf_rd0;
    rf_re0    = 1'b0;
    rf_re1    = 1'b0;
    rf_ra0    = REG_ADDR_HI;
    rf_ra1    = REG_ADDR_LO;
    rf_we     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          if (req.req_type == REQ_WRITE) begin
            mem_we    = 1'b1;
            mem_addr  = req.load_address;
            mem_wdata = req.load_data;
          end else if (!pc_out) begin
            mem_en = 1'b1;
            rf_re0 = 1'b1;
            rf_re1 = 1'b1;
          end
        end
      end
      S_F1: begin
        mem_en   = 1'b1;
        mem_addr = pc + 16'd1;
      end
      S_F2: begin
        mem_en   = 1'b1;
        mem_addr = pc + 16'd2;
        rf_re0   = 1'b1;
        rf_ra0   = mem_q[RF_AW-1:0];
      end
      S_EX: begin
        rf_re1   = 1'b1;
        rf_ra1   = mem_q[RF_AW-1:0];
        mem_en   = (op == OP_LOAD);
        mem_addr = daddr;
      end
      S_WB: begin
        mem_we   = wb_fire && do_store;
        mem_addr = daddr;
        rf_we    = wb_fire && wr_reg;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= CODE_BEGIN_RST;
      carry     <= 1'b0;
      zero      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (idle_fire || wb_fire) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (idle_fire) begin
            res.status          <= (req.req_type == REQ_WRITE) ? ST_OK : ST_PC_OUT;
            res.program_counter <= pc;
            res.carry_flag      <= carry;
            res.zero_flag       <= zero;
            res.target_register <= '0;
            res.target_value    <= '0;
          end else if (req_valid && req_ready) begin
            state <= S_F1;
          end
        end
        S_F1: begin
          op    <= mem_q;
          daddr <= {rf_rd0, rf_rd1};
          state <= S_F2;
        end
        S_F2: begin
          a1    <= mem_q;
          state <= S_EX;
        end
        S_EX: begin
          a2    <= mem_q;
          state <= S_WB;
        end
        S_WB: begin
          if (wb_fire) begin
            pc                  <= pc_next;
            carry               <= carry_next;
            zero                <= zero_next;
            res.status          <= st;
            res.program_counter <= pc_next;
            res.carry_flag      <= carry_next;
            res.zero_flag       <= zero_next;
            res.target_register <= a1[2:0];
            res.target_value    <= wr_reg ? wval : rf_rd0;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rf_write_in_wb: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> (state == S_WB) && res_free)
    else $error("Register file written outside write-back.");

  a_pc_only_on_wb: assert property (@(posedge clk) disable iff (rst)
    !wb_fire |=> $stable(pc))
    else $error("Program counter moved without a completed instruction.");

  a_flags_only_on_wb: assert property (@(posedge clk) disable iff (rst)
    !wb_fire |=> $stable(carry) && $stable(zero))
    else $error("Flags moved without a completed instruction.");

  a_no_store_into_code: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_WB)) |-> !in_code)
    else $error("Store into the code segment reached the memory.");

  a_one_result_per_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_F1) |-> !$past(idle_fire))
    else $error("Short request also started a fetch.");

endmodule

>>> rtl/core/tiny_8bit_cpu_step_top.sv
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_step_top: tiny 8-bit processor step block
// Takes byte-write and execute requests, runs them on the core and returns
// one status word per request through an output register.
//
//   channel   direction  handshake             word
//   request   in         in_valid / in_ready   req_type, load_address, load_data
//   result    out        out_valid / out_ready status, program_counter, flags,
//                                              target_register, target_value
//   config    in         cfg_we                cfg_index, cfg_data
//
// An instruction passes through the core states idle, F1, F2, EX and
// write-back: three byte fetches and a data access share the single memory
// port. A byte write or a fetch outside code is done in the idle state; the
// input buffer takes a new request only after the core has taken the last.
// Reset is synchronous and needs no clearing pass; the memory is undefined
// until written. A stalled result holds the core in write-back while the next
// request waits in the input buffer.
// ----------------------------------------------------------------------------
module tiny_8bit_cpu_step_top
  import tcpu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] load_address,
  input  logic [7:0]  load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] program_counter,
  output logic        carry_flag,
  output logic        zero_flag,
  output logic [2:0]  target_register,
  output logic [7:0]  target_value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] code_begin;
  logic [15:0] code_end;
  logic        in_full;
  req_t        req_buf;
  logic        req_ready;
  res_t        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_begin <= CODE_BEGIN_RST;
      code_end   <= CODE_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_BEGIN: code_begin <= cfg_data;
        CFG_CODE_END:   code_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !in_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (req_ready) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_buf.req_type     <= req_type;
      req_buf.load_address <= load_address;
      req_buf.load_data    <= load_data;
    end
  end

  tcpu_core u_core (
    .clk        (clk),
    .rst        (rst),
    .code_begin (code_begin),
    .code_end   (code_end),
    .req_valid  (in_full),
    .req_ready  (req_ready),
    .req        (req_buf),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign status          = res.status;
  assign program_counter = res.program_counter;
  assign carry_flag      = res.carry_flag;
  assign zero_flag       = res.zero_flag;
  assign target_register = res.target_register;
  assign target_value    = res.target_value;

endmodule

>>> tb/tiny_8bit_cpu_step_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_step_top_tb: self-checking bench for the 8-bit processor step
// A generator builds byte writes and instruction executions and predicts the
// status word of each one, while a driver and a monitor move the words over
// the valid/ready channels. Code segment settings change between phases, and
// memory is only read where it has been written first.
// ----------------------------------------------------------------------------
module tiny_8bit_cpu_step_top_tb;
  import tcpu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_TARGET = 1350;

  typedef struct packed {
    req_t req;
    res_t want;
  } job_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_WRITE;
  logic [15:0] load_address = '0;
  logic [7:0]  load_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] program_counter;
  logic        carry_flag;
  logic        zero_flag;
  logic [2:0]  target_register;
  logic [7:0]  target_value;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_CODE_BEGIN;
  logic [15:0] cfg_data = '0;

  tiny_8bit_cpu_step_top DUT (.*);

  logic [7:0]  gpr [REG_COUNT];
  logic [15:0] pc_q;
  logic        cy_q;
  logic        z_q;
  logic [15:0] cfg_begin;
  logic [15:0] cfg_end;
  logic [7:0]  mem_img [MEM_BYTES];
  bit          mem_known [MEM_BYTES];

  job_t request_q [$];
  res_t status_due [$];
  int   words_made;
  int   exec_count;
  int   results_seen;
  int   mismatches;
  int   settings_used;
  int   cycles;
  int   status_count [5];
  int   src_idle_pct;
  int   sink_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit in_code();
    return (pc_q >= cfg_begin) && ({1'b0, pc_q} + 17'd2 < {1'b0, cfg_end});
  endfunction

  function automatic logic [15:0] code_addr();
    return 16'($urandom_range(int'(cfg_begin), int'(cfg_end) - 3));
  endfunction

  function automatic res_t predict_word(req_t w);
    res_t        r;
    logic [7:0]  op, a1, a2, x, y, v;
    logic [2:0]  r1, r2;
    logic [15:0] daddr;
    logic [8:0]  sum;
    r = '0;
    r.status = ST_OK;
    if (w.req_type == REQ_WRITE) begin
      mem_img[w.load_address] = w.load_data;
      mem_known[w.load_address] = 1'b1;
    end else if (!in_code()) begin
      r.status = ST_PC_OUT;
    end else begin
      op = mem_img[pc_q];
      a1 = mem_img[pc_q + 16'd1];
      a2 = mem_img[pc_q + 16'd2];
      r1 = a1[2:0];
      r2 = a2[2:0];
      x = gpr[r1];
      y = gpr[r2];
      daddr = {gpr[REG_ADDR_HI], gpr[REG_ADDR_LO]};
      pc_q = pc_q + 16'd3;
      case (op)
        OP_LOADI: gpr[r1] = a2;
        OP_LOAD: gpr[r1] = mem_img[daddr];
        OP_STORE: begin
          if (daddr >= cfg_begin && daddr < cfg_end) begin
            r.status = ST_STORE_CODE;
          end else begin
            mem_img[daddr] = x;
            mem_known[daddr] = 1'b1;
          end
        end
        OP_ADD: begin
          sum = {1'b0, x} + {1'b0, y};
          gpr[r1] = sum[7:0];
          cy_q = sum[8];
          z_q = (sum[7:0] == 8'd0);
        end
        OP_SUB: begin
          gpr[r1] = x - y;
          cy_q = (x < y);
          z_q = (gpr[r1] == 8'd0);
        end
        OP_INC, OP_DEC, OP_AND, OP_OR, OP_XOR: begin
          case (op)
            OP_INC: v = x + 8'd1;
            OP_DEC: v = x - 8'd1;
            OP_AND: v = x & y;
            OP_OR: v = x | y;
            default: v = x ^ y;
          endcase
          gpr[r1] = v;
          cy_q = 1'b0;
          z_q = (v == 8'd0);
        end
        OP_JMP: pc_q = {a1, a2};
        OP_JZ: if (z_q) pc_q = {a1, a2};
        OP_JNZ: if (!z_q) pc_q = {a1, a2};
        OP_HALT: r.status = ST_HALT;
        default: r.status = ST_BAD_OP;
      endcase
      r.target_register = r1;
      r.target_value = gpr[r1];
    end
    r.program_counter = pc_q;
    r.carry_flag = cy_q;
    r.zero_flag = z_q;
    status_count[r.status]++;
    return r;
  endfunction

  function automatic logic [15:0] landing_pc();
    logic [7:0] op;
    op = mem_img[pc_q];
    if (op == OP_JMP || (op == OP_JZ && z_q) || (op == OP_JNZ && !z_q))
      return {mem_img[pc_q + 16'd1], mem_img[pc_q + 16'd2]};
    return pc_q + 16'd3;
  endfunction

  task automatic push_word(logic kind, logic [15:0] addr, logic [7:0] data);
    job_t j;
    j.req.req_type = kind;
    j.req.load_address = addr;
    j.req.load_data = data;
    j.want = predict_word(j.req);
    request_q.push_back(j);
    words_made++;
    if (kind == REQ_EXEC) exec_count++;
  endtask

  task automatic poke(logic [15:0] addr, logic [7:0] data);
    push_word(REQ_WRITE, addr, data);
  endtask

  task automatic exec_one();
    push_word(REQ_EXEC, 16'($urandom), 8'($urandom));
  endtask

  task automatic place_insn(logic [15:0] addr, logic [7:0] op, logic [7:0] a1, logic [7:0] a2);
    poke(addr, op);
    poke(addr + 16'd1, a1);
    poke(addr + 16'd2, a2);
  endtask

  task automatic place_random();
    logic [7:0]  op, a1, a2;
    logic [15:0] j;
    if ($urandom_range(0, 9) == 0) op = 8'($urandom_range(int'(OP_HALT) + 1, 255));
    else op = 8'($urandom_range(int'(OP_LOADI), int'(OP_HALT)));
    a1 = 8'($urandom);
    a2 = 8'($urandom);
    if (op == OP_JMP || op == OP_JZ || op == OP_JNZ) begin
      if ($urandom_range(0, 15) == 0) j = 16'($urandom_range(0, 65532));
      else j = code_addr();
      {a1, a2} = j;
    end
    place_insn(pc_q, op, a1, a2);
  endtask

  // The program counter must never rest above 65532, where no segment can
  // hold a whole instruction, and a load must never read an unwritten byte.
  task automatic safe_exec();
    logic [15:0] t, daddr;
    if (in_code()) begin
      if (!(mem_known[pc_q] && mem_known[pc_q + 16'd1] && mem_known[pc_q + 16'd2]))
        place_random();
      if (landing_pc() > 16'd65532) begin
        t = code_addr();
        place_insn(pc_q, OP_JMP, t[15:8], t[7:0]);
      end
      daddr = {gpr[REG_ADDR_HI], gpr[REG_ADDR_LO]};
      if (mem_img[pc_q] == OP_LOAD && !mem_known[daddr]) poke(daddr, 8'($urandom));
    end
    exec_one();
  endtask

  task automatic aim_and_access();
    logic [15:0] a;
    logic [7:0]  op;
    a = ($urandom_range(0, 1) == 0) ? code_addr() : 16'($urandom);
    op = ($urandom_range(0, 1) == 0) ? OP_STORE : OP_LOAD;
    place_insn(pc_q, OP_LOADI, 8'(REG_ADDR_HI), a[15:8]);
    safe_exec();
    if (in_code()) place_insn(pc_q, OP_LOADI, 8'(REG_ADDR_LO), a[7:0]);
    safe_exec();
    if (in_code()) place_insn(pc_q, op, 8'($urandom), 8'($urandom));
    safe_exec();
  endtask

  task automatic run_random(int n);
    int stop, out_runs, pick;
    stop = words_made + n;
    out_runs = 0;
    while (words_made < stop && out_runs < 2) begin
      if (!in_code()) begin
        exec_one();
        out_runs++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          poke(16'($urandom), 8'($urandom));
        end else if (pick < 20) begin
          aim_and_access();
        end else begin
          if (pick >= 40) place_random();
          safe_exec();
        end
      end
    end
  endtask

  task automatic drain();
    while (results_seen < words_made) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_code(logic [15:0] b, logic [15:0] e);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CODE_BEGIN;
    cfg_data <= b;
    @(posedge clk);
    cfg_index <= CFG_CODE_END;
    cfg_data <= e;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_begin = b;
    cfg_end = e;
    settings_used++;
  endtask

  task automatic enter_segment(logic [15:0] b, logic [15:0] e);
    logic [15:0] t;
    t = 16'($urandom_range(int'(b), int'(e) - 3));
    if (in_code()) begin
      place_insn(pc_q, OP_JMP, t[15:8], t[7:0]);
      exec_one();
    end
    drain();
    if (pc_q < b) b = pc_q;
    if ({1'b0, pc_q} + 17'd3 > {1'b0, e}) e = pc_q + 16'd3;
    write_code(b, e);
  endtask

  task automatic run_directed();
    place_insn(16'd0,  OP_LOADI, 8'hF9, 8'hFF);
    place_insn(16'd3,  OP_LOADI, 8'h02, 8'h01);
    place_insn(16'd6,  OP_ADD,   8'h01, 8'h02);
    place_insn(16'd9,  OP_SUB,   8'h03, 8'h02);
    place_insn(16'd12, OP_INC,   8'h03, 8'h00);
    place_insn(16'd15, OP_DEC,   8'h03, 8'h00);
    place_insn(16'd18, OP_AND,   8'h03, 8'h02);
    place_insn(16'd21, OP_OR,    8'h04, 8'h03);
    place_insn(16'd24, OP_XOR,   8'h04, 8'h04);
    place_insn(16'd27, OP_JZ,    8'h00, 8'd33);
    place_insn(16'd30, 8'hFF,    8'hFF, 8'hFF);
    place_insn(16'd33, OP_JNZ,   8'hFF, 8'hFF);
    place_insn(16'd36, OP_LOADI, 8'(REG_ADDR_HI), 8'h90);
    place_insn(16'd39, OP_LOADI, 8'(REG_ADDR_LO), 8'h00);
    place_insn(16'd42, OP_STORE, 8'h03, 8'h00);
    place_insn(16'd45, OP_LOAD,  8'h05, 8'h00);
    place_insn(16'd48, OP_LOADI, 8'(REG_ADDR_HI), 8'h00);
    place_insn(16'd51, OP_STORE, 8'h02, 8'h00);
    place_insn(16'd54, OP_HALT + 8'd1, 8'h00, 8'h00);
    place_insn(16'd57, OP_HALT,  8'h07, 8'h00);
    place_insn(16'd60, OP_JMP,   8'h7F, 8'hFB);
    place_insn(16'h7FFB, OP_INC, 8'h00, 8'h00);
    repeat (23) exec_one();
    poke(16'hFFFF, 8'hFF);
    poke(16'h0000, 8'h00);
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : source
    job_t held;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) status_due.push_back(held.want);
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          held = request_q.pop_front();
          in_valid <= 1'b1;
          req_type <= held.req.req_type;
          load_address <= held.req.load_address;
          load_data <= held.req.load_data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : sink
    res_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          report_mismatch("result word arrived with none outstanding");
        end else begin
          due = status_due.pop_front();
          check_field("status", 16'(status), 16'(due.status));
          check_field("program_counter", program_counter, due.program_counter);
          check_field("carry_flag", 16'(carry_flag), 16'(due.carry_flag));
          check_field("zero_flag", 16'(zero_flag), 16'(due.zero_flag));
          check_field("target_register", 16'(target_register),
                      16'(due.target_register));
          check_field("target_value", 16'(target_value), 16'(due.target_value));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tiny_8bit_cpu_step_top_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int          phase;
    logic [15:0] b, e;
    for (int i = 0; i < REG_COUNT; i++) gpr[i] = 8'd0;
    pc_q = CODE_BEGIN_RST;
    cy_q = 1'b0;
    z_q = 1'b0;
    cfg_begin = CODE_BEGIN_RST;
    cfg_end = CODE_END_RST;
    src_idle_pct = 7;
    sink_idle_pct = 61;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    drain();
    // The program counter now sits just short of the segment end; check it
    // below the segment start and against an empty segment as well.
    write_code(16'h7FFF, 16'hFFFF);
    exec_one();
    exec_one();
    drain();
    write_code(16'hFFFF, 16'h0000);
    exec_one();
    poke(16'($urandom), 8'($urandom));
    exec_one();
    drain();

    phase = 0;
    while (words_made < WORD_TARGET) begin
      if (words_made < WORD_TARGET / 3) begin
        src_idle_pct = 7;
        sink_idle_pct = 61;
      end else if (words_made < 2 * WORD_TARGET / 3) begin
        src_idle_pct = 61;
        sink_idle_pct = 7;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      case (phase % 6)
        0: begin b = 16'h0000; e = 16'hFFFF; end
        1: begin b = 16'hFFFC; e = 16'hFFFF; end
        2: begin
          b = 16'($urandom_range(0, 65000));
          e = b + 16'($urandom_range(3, 48));
        end
        3: begin b = 16'h0100; e = 16'h0140; end
        4: begin
          b = 16'($urandom_range(0, 30000));
          e = b + 16'($urandom_range(256, 30000));
        end
        default: begin b = 16'h0000; e = 16'($urandom_range(3, 600)); end
      endcase
      enter_segment(b, e);
      run_random((phase % 6 == 1) ? 30 : 150);
      drain();
      phase++;
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d words (%0d executes) over %0d code segment settings.",
             words_made, exec_count, settings_used + 1);
    $display("Status ok/halt/pc_out/store_code/bad_op: %0d/%0d/%0d/%0d/%0d, mismatches %0d.",
             status_count[ST_OK], status_count[ST_HALT], status_count[ST_PC_OUT],
             status_count[ST_STORE_CODE], status_count[ST_BAD_OP], mismatches);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("tiny_8bit_cpu_step_top_tb OK");
    end else begin
      $display("tiny_8bit_cpu_step_top_tb NOT OK");
    end
    $finish;
  end

endmodule
